// ----- hw/rtl/akps_pkg.sv -----
// ----------------------------------------------------------------------------
// akps_pkg
// Shared types, register map and constants of the key ladder and pot scanner.
// ----------------------------------------------------------------------------
package akps_pkg;

	localparam int DEFAULT_BANKS = 4;

	// shared divider: dividend width and step counter width
	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// APB register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_KEY_LEVEL_0    = 3'd0,
		REG_KEY_LEVEL_1    = 3'd1,
		REG_KEY_LEVEL_2    = 3'd2,
		REG_KEY_LEVEL_3    = 3'd3,
		REG_DEBOUNCE_COUNT = 3'd4,
		REG_LONG_PRESS     = 3'd5,
		REG_POT_LOW        = 3'd6,
		REG_POT_HIGH       = 3'd7
	} akps_reg_e;

	// key codes
	typedef logic [2:0] key_code_t;
	localparam key_code_t CODE_KEY_0   = 3'd0;
	localparam key_code_t CODE_KEY_1   = 3'd1;
	localparam key_code_t CODE_KEY_2   = 3'd2;
	localparam key_code_t CODE_KEY_3   = 3'd3;
	localparam key_code_t CODE_NONE    = 3'd4;
	localparam key_code_t CODE_UNKNOWN = 3'd5;

	// register reset values
	localparam logic [7:0]  KEY_LEVEL_0_RST    = 8'd32;
	localparam logic [7:0]  KEY_LEVEL_1_RST    = 8'd96;
	localparam logic [7:0]  KEY_LEVEL_2_RST    = 8'd160;
	localparam logic [7:0]  KEY_LEVEL_3_RST    = 8'd224;
	localparam logic [3:0]  DEBOUNCE_COUNT_RST = 4'd1;
	localparam logic [11:0] LONG_PRESS_RST     = 12'(3000 / 2);
	localparam logic [7:0]  POT_LOW_RST        = 8'd80;
	localparam logic [7:0]  POT_HIGH_RST       = 8'd255;

	typedef struct packed {
		logic [7:0]  key_level_0;
		logic [7:0]  key_level_1;
		logic [7:0]  key_level_2;
		logic [7:0]  key_level_3;
		logic [3:0]  debounce_count;
		logic [11:0] long_press_count;
		logic [7:0]  pot_low;
		logic [7:0]  pot_high;
	} akps_cfg_t;

	typedef struct packed {
		key_code_t confirmed_code;
		logic      long_flag;
		logic      event_flag;
	} akps_key_status_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       clear_event;
	} akps_req_t;

	typedef struct packed {
		logic       processed_channel;
		logic [7:0] channel_average;
		logic [2:0] key_code;
		logic       key_long;
		logic       key_event;
		logic [7:0] pot_value;
		logic [7:0] pot_normalized;
	} akps_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_AVG,
		ST_NORM_GO,
		ST_NORM_WAIT,
		ST_DONE
	} akps_state_e;

endpackage

// ----- hw/rtl/adc_key_ladder_and_pot_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// adc_key_ladder_and_pot_scanner_unit
// Key ladder and potentiometer scanner: bank averaging, debounce, long press
// and normalized pot value, normalization computed on one shared iterative
// divider.
// ----------------------------------------------------------------------------
//
//   channel   signals                                  role
//   -------   --------------------------------------   ---------------------
//   req       req_valid, req_ready, req_data           conversion word in
//   rsp       rsp_valid, rsp_ready, rsp_data           status word out
//   apb       psel, penable, pwrite, paddr, pwdata,    register access
//             prdata, pready
//
// A word is taken only in idle; its result is valid once the sequencer has
// summed the banks, formed the average (reciprocal multiply), run the divider
// over the 16-bit dividend for pot normalization, and passed its hand-offs.
// No new word is taken until the sequencer is back in idle after that.
// A finished result sits in the output register, so the next word is taken
// while rsp waits; a result that finds the register still full stalls in the
// last step. arst_n clears all control state, the sample store and registers.
// ----------------------------------------------------------------------------
module adc_key_ladder_and_pot_scanner_unit #(
	parameter int BANKS = akps_pkg::DEFAULT_BANKS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// conversion words
	input  logic                      req_valid,
	output logic                      req_ready,
	input  akps_pkg::akps_req_t       req_data,
	// result words
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output akps_pkg::akps_rsp_t       rsp_data,
	// register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [akps_pkg::ADDR_W-1:0] paddr,
	input  logic [akps_pkg::DATA_W-1:0] pwdata,
	output logic [akps_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import akps_pkg::*;

	localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int SUM_W = $clog2(255 * BANKS + 1);
	// floor(sum / BANKS) as (sum * AVG_MUL) >> AVG_SH, exact over the sum range
	localparam int AVG_SH  = SUM_W + $clog2(BANKS);
	localparam int AVG_MUL = ((1 << AVG_SH) + BANKS - 1) / BANKS;
	localparam int PROD_W  = SUM_W + AVG_SH;

	// ------------------------------------------------------------------
	// Register file
	// ------------------------------------------------------------------
	akps_cfg_t cfg_q;
	akps_reg_e reg_sel;
	logic      cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = akps_reg_e'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_level_0      <= KEY_LEVEL_0_RST;
			cfg_q.key_level_1      <= KEY_LEVEL_1_RST;
			cfg_q.key_level_2      <= KEY_LEVEL_2_RST;
			cfg_q.key_level_3      <= KEY_LEVEL_3_RST;
			cfg_q.debounce_count   <= DEBOUNCE_COUNT_RST;
			cfg_q.long_press_count <= LONG_PRESS_RST;
			cfg_q.pot_low          <= POT_LOW_RST;
			cfg_q.pot_high         <= POT_HIGH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_KEY_LEVEL_0:    cfg_q.key_level_0      <= pwdata[7:0];
				REG_KEY_LEVEL_1:    cfg_q.key_level_1      <= pwdata[7:0];
				REG_KEY_LEVEL_2:    cfg_q.key_level_2      <= pwdata[7:0];
				REG_KEY_LEVEL_3:    cfg_q.key_level_3      <= pwdata[7:0];
				REG_DEBOUNCE_COUNT: cfg_q.debounce_count   <= pwdata[3:0];
				REG_LONG_PRESS:     cfg_q.long_press_count <= pwdata[11:0];
				REG_POT_LOW:        cfg_q.pot_low          <= pwdata[7:0];
				REG_POT_HIGH:       cfg_q.pot_high         <= pwdata[7:0];
			endcase
		end
	end

	// read back, zero-extended to the bus
	always_comb begin
		unique case (reg_sel)
			REG_KEY_LEVEL_0:    prdata = DATA_W'(cfg_q.key_level_0);
			REG_KEY_LEVEL_1:    prdata = DATA_W'(cfg_q.key_level_1);
			REG_KEY_LEVEL_2:    prdata = DATA_W'(cfg_q.key_level_2);
			REG_KEY_LEVEL_3:    prdata = DATA_W'(cfg_q.key_level_3);
			REG_DEBOUNCE_COUNT: prdata = DATA_W'(cfg_q.debounce_count);
			REG_LONG_PRESS:     prdata = DATA_W'(cfg_q.long_press_count);
			REG_POT_LOW:        prdata = DATA_W'(cfg_q.pot_low);
			REG_POT_HIGH:       prdata = DATA_W'(cfg_q.pot_high);
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state and control
	// ------------------------------------------------------------------
	akps_state_e state_q, state_d;
	logic        accept;
	logic        sum_last;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic        load_out;
	logic [DIV_W-1:0] div_dividend;
	logic [7:0]  div_divisor;
	logic [DIV_W-1:0] div_quotient;

	logic             cur_ch_q;   // channel of the next word: 1 = pot
	logic [BW-1:0]    bank_q;
	logic             proc_ch_q;  // channel of the word in flight
	logic [BW-1:0]    sum_idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [PROD_W-1:0] avg_prod;
	logic [7:0]       avg_val;
	logic [7:0]       avg_q;
	logic [7:0]       pot_q;
	logic [7:0]       norm_q;
	logic             rsp_valid_q;
	akps_rsp_t        rsp_q;

	logic [7:0] store_q [2][BANKS];

	akps_key_status_t key_status;

	// pot normalization operands: clamp, offset, times 255 as shift-subtract
	logic [7:0]       pot_clamped;
	logic [7:0]       pot_offset;
	logic [DIV_W-1:0] norm_dividend;
	logic             pot_degenerate;

	assign accept   = req_valid && req_ready;
	assign sum_last = sum_idx_q == BW'(BANKS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = ST_SUM;
			ST_SUM:       if (sum_last) state_d = ST_AVG;
			ST_AVG:       state_d = ST_NORM_GO;
			ST_NORM_GO:   state_d = ST_NORM_WAIT;
			ST_NORM_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:      if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		div_start    = 1'b0;
		load_out     = 1'b0;
		div_dividend = norm_dividend;
		div_divisor  = cfg_q.pot_high - cfg_q.pot_low;
		unique case (state_q)
			ST_IDLE:    req_ready = 1'b1;
			ST_NORM_GO: div_start = 1'b1;
			ST_DONE:    load_out = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Channel rotation and sample store
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ch_q  <= 1'b1;
			bank_q    <= '0;
			proc_ch_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				for (int b = 0; b < BANKS; b++) begin
					store_q[c][b] <= '0;
				end
			end
		end else if (accept) begin
			store_q[cur_ch_q][bank_q] <= req_data.sample;
			proc_ch_q                 <= cur_ch_q;
			cur_ch_q                  <= ~cur_ch_q;
			// advance the bank after each key sample
			if (!cur_ch_q) begin
				bank_q <= (bank_q == BW'(BANKS - 1)) ? '0 : bank_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Bank sum, one entry per cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q     <= '0;
			sum_idx_q <= '0;
		end else if (state_q == ST_SUM) begin
			sum_q     <= sum_q + SUM_W'(store_q[proc_ch_q][sum_idx_q]);
			sum_idx_q <= sum_idx_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Average and normalization results
	// ------------------------------------------------------------------
	assign avg_prod = PROD_W'(sum_q) * PROD_W'(AVG_MUL);
	assign avg_val  = avg_prod[AVG_SH +: 8];

	always_comb begin
		if (pot_q < cfg_q.pot_low)       pot_clamped = cfg_q.pot_low;
		else if (pot_q > cfg_q.pot_high) pot_clamped = cfg_q.pot_high;
		else                             pot_clamped = pot_q;
		pot_offset     = pot_clamped - cfg_q.pot_low;
		norm_dividend  = {pot_offset, 8'h00} - DIV_W'(pot_offset);
		pot_degenerate = cfg_q.pot_high <= cfg_q.pot_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_q <= '0;
		end else if (state_q == ST_AVG && proc_ch_q) begin
			pot_q <= avg_val;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AVG) begin
			avg_q <= avg_val;
		end
		if (state_q == ST_NORM_WAIT && div_done) begin
			// an empty or inverted pot range reads as zero
			norm_q <= pot_degenerate ? 8'd0 : div_quotient[7:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q.processed_channel <= proc_ch_q;
			rsp_q.channel_average   <= avg_q;
			rsp_q.key_code          <= key_status.confirmed_code;
			rsp_q.key_long          <= key_status.long_flag;
			rsp_q.key_event         <= key_status.event_flag;
			rsp_q.pot_value         <= pot_q;
			rsp_q.pot_normalized    <= norm_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ------------------------------------------------------------------
	// Submodules
	// ------------------------------------------------------------------
	akps_key_debounce u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.key_chan    (!cur_ch_q),
		.sample      (req_data.sample),
		.clear_event (req_data.clear_event),
		.cfg         (cfg_q),
		.status      (key_status)
	);

	akps_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_NORM_WAIT)
		else $error("divider running outside the wait state");

	a_accept_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SUM)
		else $error("accepted word did not start the bank sum");

	a_pot_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.processed_channel |->
			rsp_q.pot_value == rsp_q.channel_average)
		else $error("pot result value differs from its bank average");

	a_key_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		key_status.confirmed_code <= CODE_UNKNOWN)
		else $error("confirmed key code out of range");

endmodule

// ----- hw/rtl/akps_divider.sv -----
// ----------------------------------------------------------------------------
// akps_divider
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module akps_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [akps_pkg::DIV_W-1:0] dividend,
	input  logic [7:0]                divisor,
	output logic                      busy,
	output logic                      done,
	output logic [akps_pkg::DIV_W-1:0] quotient
);
	import akps_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [7:0]           rem_q;
	logic [7:0]           dvs_q;
	logic [DIV_W-1:0]     quo_q;
	logic [8:0]           trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: remainder stays below the divisor, so eight bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/akps_key_debounce.sv -----
// ----------------------------------------------------------------------------
// akps_key_debounce
// Threshold decode, debounce, long-press countdown and sticky event flag.
// ----------------------------------------------------------------------------
module akps_key_debounce (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       key_chan,
	input  logic [7:0]                 sample,
	input  logic                       clear_event,
	input  akps_pkg::akps_cfg_t        cfg,
	output akps_pkg::akps_key_status_t status
);
	import akps_pkg::*;

	key_code_t   code;
	key_code_t   pending_q, pending_d;
	key_code_t   confirmed_q, confirmed_d;
	logic [3:0]  deb_left_q, deb_left_d;
	logic [11:0] hold_left_q, hold_left_d;
	logic        long_q, long_d;
	logic        event_q, event_d;

	// highest threshold first; first match wins
	always_comb begin
		if (sample >= cfg.key_level_3)     code = CODE_NONE;
		else if (sample > cfg.key_level_2) code = CODE_KEY_3;
		else if (sample > cfg.key_level_1) code = CODE_KEY_2;
		else if (sample > cfg.key_level_0) code = CODE_KEY_1;
		else                               code = CODE_KEY_0;
	end

	always_comb begin
		pending_d   = pending_q;
		confirmed_d = confirmed_q;
		deb_left_d  = deb_left_q;
		hold_left_d = hold_left_q;
		long_d      = long_q;
		event_d     = clear_event ? 1'b0 : event_q;
		if (key_chan) begin
			if (code != pending_q) begin
				pending_d  = code;
				deb_left_d = cfg.debounce_count;
			end else if (deb_left_q != '0) begin
				deb_left_d = deb_left_q - 1'b1;
				if (deb_left_q == 4'd1) begin
					confirmed_d = pending_q;
					long_d      = 1'b0;
					event_d     = 1'b1;
					hold_left_d = (pending_q != CODE_NONE) ? cfg.long_press_count : '0;
				end
			end else if (hold_left_q != '0) begin
				hold_left_d = hold_left_q - 1'b1;
				if (hold_left_q == 12'd1) begin
					long_d  = 1'b1;
					event_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= CODE_UNKNOWN;
			confirmed_q <= CODE_UNKNOWN;
			deb_left_q  <= '0;
			hold_left_q <= '0;
			long_q      <= 1'b0;
			event_q     <= 1'b0;
		end else if (step) begin
			pending_q   <= pending_d;
			confirmed_q <= confirmed_d;
			deb_left_q  <= deb_left_d;
			hold_left_q <= hold_left_d;
			long_q      <= long_d;
			event_q     <= event_d;
		end
	end

	assign status.confirmed_code = confirmed_q;
	assign status.long_flag      = long_q;
	assign status.event_flag     = event_q;

endmodule

// ----- dv/adc_key_ladder_and_pot_scanner_unit_test.sv -----
// ----------------------------------------------------------------------------
// adc_key_ladder_and_pot_scanner_unit_test
// Self-checking bench for the key ladder and pot scanner: a short directed
// plan, then randomized phases under varied register settings, all results
// scored field by field against a cycle-free model of the scanner or, for some directed words, a hand-typed status.
// ----------------------------------------------------------------------------
module adc_key_ladder_and_pot_scanner_unit_test;
	import akps_pkg::*;

	localparam int BANKS = DEFAULT_BANKS;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 116;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	akps_req_t           req_data;
	logic                rsp_valid;
	logic                rsp_ready;
	akps_rsp_t           rsp_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	adc_key_ladder_and_pot_scanner_unit #(.BANKS(BANKS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scanner model: its own copy of the registers and the scan state.
	// ------------------------------------------------------------------
	akps_cfg_t   cfg;
	logic        cur_ch;
	logic [$clog2(BANKS)-1:0] bank_idx;
	logic [7:0]  store [2][BANKS];
	key_code_t   pend_code;
	key_code_t   conf_code;
	logic [3:0]  deb_left;
	logic [11:0] hold_left;
	logic        long_f;
	logic        evt_f;
	logic [7:0]  pot_reg;

	// status words still owed by the block, oldest first
	akps_rsp_t   status_due[$];
	int          error_count = 0;

	// stimulus-side controls read by the receiver
	bit          calm = 1'b0;
	int          hold_off_reqs = 0;

	function automatic logic [7:0] bank_mean(logic ch);
		int sum;
		sum = 0;
		for (int b = 0; b < BANKS; b++) sum += int'(store[ch][b]);
		return 8'(sum / BANKS);
	endfunction

	function automatic void scan_reset();
		cfg.key_level_0      = KEY_LEVEL_0_RST;
		cfg.key_level_1      = KEY_LEVEL_1_RST;
		cfg.key_level_2      = KEY_LEVEL_2_RST;
		cfg.key_level_3      = KEY_LEVEL_3_RST;
		cfg.debounce_count   = DEBOUNCE_COUNT_RST;
		cfg.long_press_count = LONG_PRESS_RST;
		cfg.pot_low          = POT_LOW_RST;
		cfg.pot_high         = POT_HIGH_RST;
		cur_ch    = 1'b1;
		bank_idx  = '0;
		for (int c = 0; c < 2; c++)
			for (int b = 0; b < BANKS; b++) store[c][b] = '0;
		pend_code = CODE_UNKNOWN;
		conf_code = CODE_UNKNOWN;
		deb_left  = '0;
		hold_left = '0;
		long_f    = 1'b0;
		evt_f     = 1'b0;
		pot_reg   = '0;
	endfunction

	// Advance the scan by one conversion word and return the status it yields.
	function automatic akps_rsp_t scan_step(akps_req_t w);
		logic      ch;
		key_code_t code;
		akps_rsp_t r;
		int        v;
		ch = cur_ch;
		if (w.clear_event) evt_f = 1'b0;
		store[ch][bank_idx] = w.sample;
		if (ch == 1'b0) begin
			// thresholds are tested top down; first hit wins even if unordered
			if (w.sample >= cfg.key_level_3) code = CODE_NONE;
			else if (w.sample > cfg.key_level_2) code = CODE_KEY_3;
			else if (w.sample > cfg.key_level_1) code = CODE_KEY_2;
			else if (w.sample > cfg.key_level_0) code = CODE_KEY_1;
			else code = CODE_KEY_0;
			if (code != pend_code) begin
				pend_code = code;
				deb_left  = cfg.debounce_count;
			end else if (deb_left != 0) begin
				deb_left--;
				if (deb_left == 0) begin
					conf_code = pend_code;
					long_f    = 1'b0;
					evt_f     = 1'b1;
					hold_left = (conf_code != CODE_NONE) ? cfg.long_press_count : 12'd0;
				end
			end else if (hold_left != 0) begin
				hold_left--;
				if (hold_left == 0) begin
					long_f = 1'b1;
					evt_f  = 1'b1;
				end
			end
			bank_idx = (int'(bank_idx) + 1 >= BANKS) ? '0 : bank_idx + 1'b1;
			cur_ch   = 1'b1;
		end else begin
			pot_reg = bank_mean(1'b1);
			cur_ch  = 1'b0;
		end
		r.processed_channel = ch;
		r.channel_average   = bank_mean(ch);
		r.key_code          = conf_code;
		r.key_long          = long_f;
		r.key_event         = evt_f;
		r.pot_value         = pot_reg;
		if (cfg.pot_high <= cfg.pot_low) begin
			r.pot_normalized = '0;
		end else begin
			v = int'(pot_reg);
			if (v < int'(cfg.pot_low)) v = int'(cfg.pot_low);
			if (v > int'(cfg.pot_high)) v = int'(cfg.pot_high);
			r.pot_normalized = 8'(((v - int'(cfg.pot_low)) * 255) /
				(int'(cfg.pot_high) - int'(cfg.pot_low)));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed plan rows: a conversion word, a register write, or a word
	// whose status is typed in by hand.
	// ------------------------------------------------------------------
	typedef struct {
		bit          is_reg;
		akps_reg_e   sel;
		logic [31:0] value;
		akps_req_t   word;
		bit          typed;
		akps_rsp_t   want;
	} plan_row_t;

	function automatic plan_row_t word_row(int s, bit clr);
		plan_row_t r;
		r.is_reg = 1'b0;
		r.sel    = REG_KEY_LEVEL_0;
		r.value  = '0;
		r.word.sample      = 8'(s);
		r.word.clear_event = clr;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic plan_row_t reg_row(akps_reg_e sel, int value);
		plan_row_t r;
		r = word_row(0, 1'b0);
		r.is_reg = 1'b1;
		r.sel    = sel;
		r.value  = 32'(value);
		return r;
	endfunction

	function automatic plan_row_t status_row(int s, bit clr, bit ch, int avg, key_code_t code,
			bit lng, bit evt, int pot, int norm);
		plan_row_t r;
		r = word_row(s, clr);
		r.typed = 1'b1;
		r.want.processed_channel = ch;
		r.want.channel_average   = 8'(avg);
		r.want.key_code          = code;
		r.want.key_long          = lng;
		r.want.key_event         = evt;
		r.want.pot_value         = 8'(pot);
		r.want.pot_normalized    = 8'(norm);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver tasks. Each starts and ends on a rising edge.
	// ------------------------------------------------------------------
	task automatic write_reg(akps_reg_e sel, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (sel)
			REG_KEY_LEVEL_0:    cfg.key_level_0      = value[7:0];
			REG_KEY_LEVEL_1:    cfg.key_level_1      = value[7:0];
			REG_KEY_LEVEL_2:    cfg.key_level_2      = value[7:0];
			REG_KEY_LEVEL_3:    cfg.key_level_3      = value[7:0];
			REG_DEBOUNCE_COUNT: cfg.debounce_count   = value[3:0];
			REG_LONG_PRESS:     cfg.long_press_count = value[11:0];
			REG_POT_LOW:        cfg.pot_low          = value[7:0];
			REG_POT_HIGH:       cfg.pot_high         = value[7:0];
			default: ;
		endcase
		// idle before returning so the next setup phase never lands on this edge
		@(posedge clk);
	endtask

	// Offer one word, hold it until taken, then book its expected status.
	task automatic send_word(akps_req_t w, bit typed, akps_rsp_t want);
		akps_rsp_t predicted;
		req_valid <= 1'b1;
		req_data  <= w;
		do @(posedge clk); while (!req_ready);
		predicted = scan_step(w);
		status_due.push_back(typed ? want : predicted);
	endtask

	// Random sender gap: drop valid for a burst, unless in the calm tail.
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every booked status word has come back.
	task automatic settle();
		req_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		plan_row_t   plan[$];
		logic [7:0]  lvl[4];
		int          lvq[$];
		int          pot_lo, pot_hi, deb, lp, run_left, run_max;
		logic [7:0]  held;
		logic [15:0] field[8];
		akps_req_t   w;

		scan_reset();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed plan ---
		// first words after reset: pot bank fills, key 0 pending then confirmed
		plan.push_back(status_row(255, 1'b0, 1'b1, 63, CODE_UNKNOWN, 1'b0, 1'b0, 63, 0));
		plan.push_back(status_row(0, 1'b1, 1'b0, 0, CODE_UNKNOWN, 1'b0, 1'b0, 63, 0));
		plan.push_back(status_row(255, 1'b0, 1'b1, 127, CODE_UNKNOWN, 1'b0, 1'b0, 127, 68));
		plan.push_back(status_row(0, 1'b0, 1'b0, 0, CODE_KEY_0, 1'b0, 1'b1, 127, 68));
		// short long press: change to key 2, confirm, hold through to long press
		plan.push_back(reg_row(REG_LONG_PRESS, 2));
		plan.push_back(word_row(128, 1'b0));
		plan.push_back(word_row(100, 1'b0));
		plan.push_back(word_row(0, 1'b0));
		plan.push_back(word_row(100, 1'b1));
		plan.push_back(word_row(200, 1'b0));
		plan.push_back(word_row(100, 1'b0));
		plan.push_back(word_row(77, 1'b0));
		plan.push_back(word_row(100, 1'b0));
		// release: none pending, then confirmed by a sample equal to key level 3
		plan.push_back(word_row(255, 1'b1));
		plan.push_back(word_row(255, 1'b0));
		plan.push_back(word_row(80, 1'b0));
		plan.push_back(word_row(224, 1'b0));
		// boundary samples for key 0 and key 3
		plan.push_back(word_row(1, 1'b0));
		plan.push_back(word_row(32, 1'b0));
		plan.push_back(word_row(254, 1'b0));
		plan.push_back(word_row(223, 1'b0));
		// zero debounce, inverted pot range, thresholds out of order
		plan.push_back(reg_row(REG_DEBOUNCE_COUNT, 0));
		plan.push_back(reg_row(REG_POT_LOW, 200));
		plan.push_back(reg_row(REG_POT_HIGH, 100));
		plan.push_back(reg_row(REG_KEY_LEVEL_3, 10));
		plan.push_back(reg_row(REG_KEY_LEVEL_2, 200));
		plan.push_back(reg_row(REG_KEY_LEVEL_1, 50));
		plan.push_back(reg_row(REG_KEY_LEVEL_0, 255));
		plan.push_back(word_row(150, 1'b0));
		plan.push_back(word_row(5, 1'b0));
		plan.push_back(word_row(255, 1'b1));
		plan.push_back(word_row(5, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].sel, plan[i].value);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
				sender_gap();
			end
		end

		// --- random phases, each under a fresh register setting ---
		run_left = 0;
		held     = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();

			case (ph % 5)
				0, 4: begin
					lvq.delete();
					repeat (4) lvq.push_back($urandom_range(0, 255));
					lvq.sort();
					foreach (lvl[k]) lvl[k] = 8'(lvq[k]);
				end
				1: foreach (lvl[k]) lvl[k] = 8'd0;
				3: foreach (lvl[k]) lvl[k] = 8'd255;
				default: foreach (lvl[k]) lvl[k] = 8'($urandom_range(0, 255));
			endcase
			deb = (ph == 1) ? 15 : (ph == 3) ? 0 : $urandom_range(1, 6);
			lp  = (ph == 2) ? 4095 : (ph == 4) ? 0 : $urandom_range(1, 25);
			case (ph % 4)
				0: begin
					pot_lo = 0;
					pot_hi = 255;
				end
				1: begin
					pot_lo = $urandom_range(0, 255);
					pot_hi = pot_lo;
				end
				2: begin
					pot_lo = $urandom_range(1, 255);
					pot_hi = $urandom_range(0, pot_lo - 1);
				end
				default: begin
					pot_lo = $urandom_range(0, 254);
					pot_hi = pot_lo + ((ph == 7) ? 1 : $urandom_range(1, 255 - pot_lo));
				end
			endcase
			field[REG_KEY_LEVEL_0]    = 16'(lvl[0]);
			field[REG_KEY_LEVEL_1]    = 16'(lvl[1]);
			field[REG_KEY_LEVEL_2]    = 16'(lvl[2]);
			field[REG_KEY_LEVEL_3]    = 16'(lvl[3]);
			field[REG_DEBOUNCE_COUNT] = 16'(deb);
			field[REG_LONG_PRESS]     = 16'(lp);
			field[REG_POT_LOW]        = 16'(pot_lo);
			field[REG_POT_HIGH]       = 16'(pot_hi);
			// junk in the upper half must be masked off by the register
			for (int k = 0; k < 8; k++)
				write_reg(akps_reg_e'(k), {16'($urandom), field[k]});

			calm    = (ph == PHASES - 1);
			run_max = (deb + lp + 3 > 40) ? 40 : deb + lp + 3;

			for (int n = 0; n < PHASE_WORDS; n++) begin
				// receiver holds off long while words keep coming
				if (ph == 1 && n == 20) hold_off_reqs++;
				// sender pauses until the pipe is empty
				if (ph == 2 && n == 50) settle();

				w.clear_event = ($urandom_range(0, 3) == 0);
				if (cur_ch) begin
					case ($urandom_range(0, 9))
						0:       w.sample = 8'd0;
						1:       w.sample = 8'd255;
						default: w.sample = 8'($urandom_range(0, 255));
					endcase
				end else begin
					// mostly held presses, some long enough to confirm and go long
					if (run_left == 0) begin
						case ($urandom_range(0, 5))
							0: held = cfg.key_level_0;
							1: held = cfg.key_level_3;
							2: held = cfg.key_level_2 + 8'd1;
							default: held = 8'($urandom_range(0, 255));
						endcase
						run_left = $urandom_range(1, run_max);
					end
					run_left--;
					w.sample = ($urandom_range(0, 9) < 2) ? 8'($urandom_range(0, 255)) : held;
				end
				send_word(w, 1'b0, '0);
				sender_gap();
			end
		end

		// --- drain and report ---
		settle();
		repeat (BANKS + 40) @(posedge clk);
		if (status_due.size() != 0)
			$error("%0d status words never arrived", status_due.size());
		if (error_count == 0 && status_due.size() == 0)
			$display("adc_key_ladder_and_pot_scanner_unit regression: pass");
		else
			$display("adc_key_ladder_and_pot_scanner_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off on request, none
	// in the calm tail.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_off_seen;
		stall_left    = 0;
		hold_off_seen = 0;
		rsp_ready     = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_reqs != hold_off_seen) begin
				hold_off_seen = hold_off_reqs;
				stall_left    = 500;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: compare each taken status word with the oldest booking.
	// ------------------------------------------------------------------
	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		akps_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status_due.size() == 0) begin
				$error("status word with nothing booked");
				error_count++;
			end else begin
				want = status_due.pop_front();
				check_field("processed_channel", 32'(want.processed_channel),
					32'(rsp_data.processed_channel));
				check_field("channel_average", 32'(want.channel_average),
					32'(rsp_data.channel_average));
				check_field("key_code", 32'(want.key_code), 32'(rsp_data.key_code));
				check_field("key_long", 32'(want.key_long), 32'(rsp_data.key_long));
				check_field("key_event", 32'(want.key_event), 32'(rsp_data.key_event));
				check_field("pot_value", 32'(want.pot_value), 32'(rsp_data.pot_value));
				check_field("pot_normalized", 32'(want.pot_normalized),
					32'(rsp_data.pot_normalized));
			end
		end
	end

	// Watchdog: generous bound on the slowest legal run.
	initial begin
		#6000000;
		$display("adc_key_ladder_and_pot_scanner_unit regression: fail");
		$finish;
	end

endmodule
